/* hw/rtl/tbrl_pkg.sv */
// shared types and constants of the token bucket rate limiter
package tbrl_pkg;

  localparam int FRAC_BITS = 16;

  localparam int TOK_W   = 32;
  localparam int RATE_W  = 32;
  localparam int BURST_W = 16;
  localparam int WAIT_W  = 32;
  localparam int ELAP_W  = 16;
  localparam int CNT_W   = 32;
  localparam int PROD_W  = ELAP_W + RATE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BURST    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT = CFG_IDX_W'(2);

  localparam logic [RATE_W-1:0]  RATE_RST     = '0;
  localparam logic [BURST_W-1:0] BURST_RST    = BURST_W'(1);
  localparam logic [WAIT_W-1:0]  MAX_WAIT_RST = WAIT_W'(1000000);

  localparam logic [TOK_W-1:0] ONE_TOKEN = TOK_W'(64'd1 << FRAC_BITS);

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  typedef enum logic [1:0] {
    ST_GRANTED = 2'd0,
    ST_DENIED  = 2'd1,
    ST_BUSY    = 2'd2
  } status_e;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [TOK_W-1:0]  cap;
    logic [WAIT_W-1:0] max_wait;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    status_e          status;
    logic [CNT_W-1:0] issued;
    logic [TOK_W-1:0] tokens;
  } result_t;

  // capacity in fixed point, saturated to the token width
  function automatic logic [TOK_W-1:0] capacity(input logic [BURST_W-1:0] burst);
    logic [63:0] wide;
    logic [BURST_W-1:0] b;
    b = (burst == '0) ? BURST_W'(1) : burst;
    wide = 64'(b) << FRAC_BITS;
    return (|wide[63:TOK_W]) ? {TOK_W{1'b1}} : wide[TOK_W-1:0];
  endfunction

endpackage

/* hw/rtl/token_bucket_rate_limiter.sv */
// token bucket rate limiter top level: input register, bucket, result register
// an accepted word is held in the input register, then its result word in the result register
// throughput: one word per cycle while out_stall_i is low; the multiply sits before the input register and
// the add, saturate and compare on the token register sit before the result register
// a word that causes no result still takes one slot in the pipeline
// reset: asynchronous active low; bucket full at one token, rate zero, wait 1000000
module token_bucket_rate_limiter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tbrl_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             kind_i,
  input  logic [tbrl_pkg::ELAP_W-1:0]      elapsed_ticks_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [tbrl_pkg::CNT_W-1:0]       issued_count_o,
  output logic [tbrl_pkg::TOK_W-1:0]       tokens_available_o
);

  tbrl_pkg::cfg_t    cfg;
  tbrl_pkg::result_t res;
  logic              refill;
  logic [tbrl_pkg::TOK_W-1:0] refill_cap;

  logic                        s1_valid_q;
  logic                        s1_kind_q;
  logic [tbrl_pkg::ELAP_W-1:0] s1_elapsed_q;
  logic [tbrl_pkg::PROD_W-1:0] s1_prod_q, s1_prod_d;

  logic                        out_valid_q;
  tbrl_pkg::status_e           out_status_q;
  logic [tbrl_pkg::CNT_W-1:0]  out_issued_q;
  logic [tbrl_pkg::TOK_W-1:0]  out_tokens_q;

  logic adv, accept, step;

  tbrl_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cfg_o        (cfg),
    .refill_o     (refill),
    .refill_cap_o (refill_cap)
  );

  // result register free or being emptied this cycle
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign step       = s1_valid_q && adv;

  // refill amount for tick words, zero for requests
  assign s1_prod_d = (kind_i == tbrl_pkg::KIND_TICK)
                   ? tbrl_pkg::PROD_W'(elapsed_ticks_i) * tbrl_pkg::PROD_W'(cfg.rate)
                   : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q    <= kind_i;
      s1_elapsed_q <= elapsed_ticks_i;
      s1_prod_q    <= s1_prod_d;
    end
  end

  tbrl_bucket u_bucket (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .kind_i       (s1_kind_q),
    .elapsed_i    (s1_elapsed_q),
    .prod_i       (s1_prod_q),
    .cfg_i        (cfg),
    .refill_i     (refill),
    .refill_cap_i (refill_cap),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= step && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      out_status_q <= res.status;
      out_issued_q <= res.issued;
      out_tokens_q <= res.tokens;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign issued_count_o     = out_issued_q;
  assign tokens_available_o = out_tokens_q;

endmodule

/* hw/rtl/tbrl_cfg.sv */
// configuration registers with the derived bucket capacity
module tbrl_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tbrl_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output tbrl_pkg::cfg_t                   cfg_o,
  output logic                             refill_o,
  output logic [tbrl_pkg::TOK_W-1:0]       refill_cap_o
);

  logic [tbrl_pkg::RATE_W-1:0] rate_q;
  logic [tbrl_pkg::TOK_W-1:0]  cap_q, cap_d;
  logic [tbrl_pkg::WAIT_W-1:0] max_wait_q;
  logic                        hit;

  always_comb begin
    hit   = 1'b0;
    cap_d = cap_q;
    case (cfg_idx_i)
      tbrl_pkg::CFG_RATE:     hit = 1'b1;
      tbrl_pkg::CFG_BURST: begin
        hit   = 1'b1;
        cap_d = tbrl_pkg::capacity(cfg_wdata_i[tbrl_pkg::BURST_W-1:0]);
      end
      tbrl_pkg::CFG_MAX_WAIT: hit = 1'b1;
      default:                hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q     <= tbrl_pkg::RATE_RST;
      cap_q      <= tbrl_pkg::capacity(tbrl_pkg::BURST_RST);
      max_wait_q <= tbrl_pkg::MAX_WAIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tbrl_pkg::CFG_RATE) rate_q <= cfg_wdata_i[tbrl_pkg::RATE_W-1:0];
      if (cfg_idx_i == tbrl_pkg::CFG_MAX_WAIT) begin
        max_wait_q <= cfg_wdata_i[tbrl_pkg::WAIT_W-1:0];
      end
      cap_q <= cap_d;
    end
  end

  assign cfg_o.rate     = rate_q;
  assign cfg_o.cap      = cap_q;
  assign cfg_o.max_wait = max_wait_q;
  // any valid write refills the bucket to the capacity in force after it
  assign refill_o       = cfg_we_i && hit;
  assign refill_cap_o   = cap_d;

endmodule

/* hw/rtl/tbrl_bucket.sv */
// token state and the per-word grant, deny and busy decision
module tbrl_bucket (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          kind_i,
  input  logic [tbrl_pkg::ELAP_W-1:0]   elapsed_i,
  input  logic [tbrl_pkg::PROD_W-1:0]   prod_i,
  input  tbrl_pkg::cfg_t                cfg_i,
  input  logic                          refill_i,
  input  logic [tbrl_pkg::TOK_W-1:0]    refill_cap_i,
  output tbrl_pkg::result_t             res_o
);

  logic [tbrl_pkg::TOK_W-1:0]  tokens_q, tokens_d;
  logic                        pending_q, pending_d;
  logic [tbrl_pkg::WAIT_W-1:0] waited_q, waited_d;
  logic [tbrl_pkg::CNT_W-1:0]  granted_q, granted_d;

  logic [tbrl_pkg::PROD_W:0]   sum;
  logic [tbrl_pkg::TOK_W-1:0]  filled;
  logic [tbrl_pkg::WAIT_W:0]   wsum;
  logic [tbrl_pkg::WAIT_W-1:0] wsat;
  logic                        rate_zero;

  always_comb begin
    // tokens never exceed capacity, so a zero product leaves them as they are
    sum    = (tbrl_pkg::PROD_W+1)'(tokens_q) + (tbrl_pkg::PROD_W+1)'(prod_i);
    filled = (sum > (tbrl_pkg::PROD_W+1)'(cfg_i.cap)) ? cfg_i.cap
                                                       : sum[tbrl_pkg::TOK_W-1:0];
    wsum   = (tbrl_pkg::WAIT_W+1)'(waited_q) + (tbrl_pkg::WAIT_W+1)'(elapsed_i);
    wsat   = wsum[tbrl_pkg::WAIT_W] ? {tbrl_pkg::WAIT_W{1'b1}}
                                    : wsum[tbrl_pkg::WAIT_W-1:0];
    rate_zero = (cfg_i.rate == '0);

    tokens_d     = tokens_q;
    pending_d    = pending_q;
    waited_d     = waited_q;
    granted_d    = granted_q;
    res_o.valid  = 1'b0;
    res_o.status = tbrl_pkg::ST_GRANTED;

    if (kind_i == tbrl_pkg::KIND_TICK) begin
      tokens_d = filled;
      if (pending_q) begin
        if (rate_zero || filled >= tbrl_pkg::ONE_TOKEN) begin
          if (!rate_zero) tokens_d = filled - tbrl_pkg::ONE_TOKEN;
          granted_d   = granted_q + 1'b1;
          pending_d   = 1'b0;
          waited_d    = '0;
          res_o.valid = 1'b1;
        end else if (wsat >= cfg_i.max_wait) begin
          pending_d    = 1'b0;
          waited_d     = '0;
          res_o.valid  = 1'b1;
          res_o.status = tbrl_pkg::ST_DENIED;
        end else begin
          waited_d = wsat;
        end
      end
    end else begin
      if (pending_q) begin
        res_o.valid  = 1'b1;
        res_o.status = tbrl_pkg::ST_BUSY;
      end else if (rate_zero || tokens_q >= tbrl_pkg::ONE_TOKEN) begin
        if (!rate_zero) tokens_d = tokens_q - tbrl_pkg::ONE_TOKEN;
        granted_d   = granted_q + 1'b1;
        res_o.valid = 1'b1;
      end else begin
        pending_d = 1'b1;
        waited_d  = '0;
      end
    end

    res_o.issued = granted_d;
    res_o.tokens = tokens_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tokens_q  <= tbrl_pkg::capacity(tbrl_pkg::BURST_RST);
      pending_q <= 1'b0;
      waited_q  <= '0;
      granted_q <= '0;
    end else begin
      if (step_i) begin
        tokens_q  <= tokens_d;
        pending_q <= pending_d;
        waited_q  <= waited_d;
        granted_q <= granted_d;
      end
      if (refill_i) tokens_q <= refill_cap_i;
    end
  end

  // a wait count only exists for a pending request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (waited_q != '0) |-> pending_q)
    else $error("wait count without pending request");

  // bucket never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tokens_q <= cfg_i.cap)
    else $error("tokens above capacity");

  // a busy answer leaves the bucket and the grant count alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && kind_i == tbrl_pkg::KIND_REQ && pending_q && !refill_i)
      |=> $stable(tokens_q) && $stable(granted_q) && pending_q)
    else $error("busy request changed state");

  // grant count moves only with a grant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i && res_o.valid && res_o.status == tbrl_pkg::ST_GRANTED)
      |=> $stable(granted_q))
    else $error("grant count moved without a grant");

endmodule
